>>> hw/rtl/b64d_pkg.sv
// Shared types, character codes and the sextet lookup for the base64 decoder.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BS    = 8'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One queue entry: up to three decoded bytes of a group.
    // A count of zero with last set is the empty end marker.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Both alphabets map here; bytes of 128 and above fall through as invalid.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r.value = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c inside {8'h2B, 8'h2D}) begin
            r.value = 6'd62;
        end else if (c inside {8'h2F, 8'h5F}) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/base64_lenient_decoder_core.sv
// Top level of the streaming base64 decoder.
//
// Decodes base64 text one character per transfer, accepting both the standard and the
// URL-safe alphabet, and returns one decoded byte per output transfer. A character is
// taken every cycle while the four-entry group queue has room; the front end handles
// one character per cycle; while m_tready is high, the serializer drains one byte
// per cycle, so one character per cycle is sustained (four characters give three
// bytes). Groups pass the queue, the current-entry register and the output register.
// '=' or a non-alphabet character (bar those the formatting flag admits) stops
// decoding until the end of the text; after the s_tlast character, a partial group
// is flushed and the last byte carries m_tlast, or, if none is left, a single empty
// marker (m_tuser low) does. The formatting flag may be written only while idle.
`default_nettype none

module base64_lenient_decoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] char_in
    input  wire logic       s_tlast,    // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] byte_out
    output logic            m_tuser,    // [0] byte_valid
    output logic            m_tlast,    // end_of_output
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data    // accept_formatting
);
    import b64d_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    entry_t q_head;

    assign cfg_ready = 1'b1;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .queue_full (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/b64d_front.sv
// Front end: takes characters, applies the skip and stop rules, and packs groups.
`default_nettype none

module b64d_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tlast,
    input  wire logic            cfg_valid,
    input  wire logic            cfg_data,
    input  wire logic            queue_full,
    output logic                 push,
    output b64d_pkg::entry_t     push_entry
);
    import b64d_pkg::*;

    logic        fmt_reg;
    logic [17:0] store_reg, store_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        cr_reg, cr_next;
    logic        lf_reg, lf_next;
    logic        seen_reg, seen_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic        take;
    sextet_t     sx;
    logic [17:0] store_mid;
    logic [1:0]  cnt_mid;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign sx       = sextet_of(s_tdata);

    always_comb
    begin
        store_next  = store_reg;
        cnt_next    = cnt_reg;
        cr_next     = cr_reg;
        lf_next     = lf_reg;
        seen_next   = seen_reg;
        halted_next = halted_reg;
        take        = 1'b0;
        push        = 1'b0;
        push_entry  = '0;
        store_mid   = store_reg;
        cnt_mid     = cnt_reg;

        if (accept) begin
            if (!halted_reg) begin
                if (s_tdata == CH_PAD) begin
                    halted_next = 1'b1;
                end else if (fmt_reg && s_tdata == CH_LF) begin
                    if (lf_reg) halted_next = 1'b1;
                    else        lf_next = 1'b1;
                end else if (fmt_reg && s_tdata == CH_CR) begin
                    if (cr_reg) halted_next = 1'b1;
                    else        cr_next = 1'b1;
                end else if (fmt_reg && (s_tdata == CH_SPACE || s_tdata == CH_BS)) begin
                    if (seen_reg) begin
                        halted_next = 1'b1;
                    end else begin
                        cr_next = 1'b1;
                        lf_next = 1'b1;
                    end
                end else if (!sx.valid) begin
                    halted_next = 1'b1;
                end else begin
                    take = 1'b1;
                end
            end

            if (take) begin
                cr_next   = 1'b0;
                lf_next   = 1'b0;
                seen_next = 1'b1;
                if (cnt_reg == 2'd3) begin
                    push             = 1'b1;
                    push_entry.word  = {store_reg, sx.value};
                    push_entry.count = 2'd3;
                    store_mid        = '0;
                    cnt_mid          = 2'd0;
                end else begin
                    store_mid = {store_reg[11:0], sx.value};
                    cnt_mid   = cnt_reg + 2'd1;
                end
            end
            store_next = store_mid;
            cnt_next   = cnt_mid;

            if (s_tlast) begin
                // A partial group is flushed only when no full group left this item.
                push            = 1'b1;
                push_entry.last = 1'b1;
                if (!(take && cnt_reg == 2'd3)) begin
                    case (cnt_mid)
                        2'd2:
                        begin
                            push_entry.word  = {store_mid[11:0], 12'd0};
                            push_entry.count = 2'd1;
                        end
                        2'd3:
                        begin
                            push_entry.word  = {store_mid, 6'd0};
                            push_entry.count = 2'd2;
                        end
                        default:
                        begin
                            push_entry.word  = '0;
                            push_entry.count = 2'd0;
                        end
                    endcase
                end
                store_next  = '0;
                cnt_next    = 2'd0;
                cr_next     = 1'b1;
                lf_next     = 1'b1;
                seen_next   = 1'b0;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg    <= 1'b0;
            store_reg  <= '0;
            cnt_reg    <= 2'd0;
            cr_reg     <= 1'b1;
            lf_reg     <= 1'b1;
            seen_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                fmt_reg <= cfg_data;
            end
            store_reg  <= store_next;
            cnt_reg    <= cnt_next;
            cr_reg     <= cr_next;
            lf_reg     <= lf_next;
            seen_reg   <= seen_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_queue.sv
// Small entry queue between the front end and the byte serializer.
`default_nettype none

module b64d_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire b64d_pkg::entry_t   push_entry,
    input  wire logic               pop,
    output logic                    full,
    output logic                    not_empty,
    output b64d_pkg::entry_t        head
);
    import b64d_pkg::*;

    entry_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_back.sv
// Back end: turns queue entries into single-byte results behind an output register.
`default_nettype none

module b64d_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_not_empty,
    input  wire b64d_pkg::entry_t   q_head,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);
    import b64d_pkg::*;

    entry_t      cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_bvalid_reg;
    logic        out_last_reg;

    logic        emit;
    logic        final_one;
    logic [7:0]  sel_byte;

    assign emit = cur_valid_reg && (!out_valid_reg || m_tready);
    // The empty marker (count zero) is a single result.
    assign final_one = (cur_reg.count == 2'd0) || (idx_reg == cur_reg.count - 2'd1);
    assign q_pop = q_not_empty && (!cur_valid_reg || (emit && final_one));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.word[23:16];
            2'd1:    sel_byte = cur_reg.word[15:8];
            2'd2:    sel_byte = cur_reg.word[7:0];
            default: sel_byte = 8'd0;
        endcase
        if (cur_reg.count == 2'd0) begin
            sel_byte = 8'd0;
        end

        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (emit) begin
            idx_next = idx_reg + 2'd1;
            if (final_one) cur_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (emit) begin
            out_byte_reg   <= sel_byte;
            out_bvalid_reg <= (cur_reg.count != 2'd0);
            out_last_reg   <= cur_reg.last && final_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (emit)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
